// ===== rtl/dwt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dwt_pkg;
    localparam int REG_IDS_DEF     = 256;
    localparam int MEM_ENTRIES_DEF = 64;
    localparam int REG_W  = 8;
    localparam int ADDR_W = 48;
    localparam int CTX_W  = 31;
    localparam int CNT_W  = 16;
    localparam int TOT_W  = 32;
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic              is_write;
        logic              is_mem;
        logic              reg_ok;
        logic [REG_W-1:0]  reg_number;
        logic [ADDR_W-1:0] address;
        logic [CTX_W-1:0]  ctx;
    } t_item;
endpackage
`default_nettype wire

// ===== rtl/dwt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dwt_front
    import dwt_pkg::*;
#(
    parameter int REG_IDS = REG_IDS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic              i_operation,
    input  wire logic              i_is_memory,
    input  wire logic [REG_W-1:0]  i_reg_number,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic [CTX_W-1:0]  i_access_context,
    output logic                   o_q_valid,
    input  wire logic              i_q_pop,
    output t_item                  o_q_item
);
    // two-entry queue between front and back
    t_item r_q [2];
    logic [1:0] r_cnt;
    logic r_rd;
    logic r_wr;
    logic push;
    t_item it;

    always_comb begin
        it.is_write   = (i_operation == OP_WRITE);
        it.is_mem     = i_is_memory;
        it.reg_ok     = ({24'd0, i_reg_number} < 32'(REG_IDS));
        it.reg_number = i_reg_number;
        it.address    = i_address;
        it.ctx        = i_access_context;
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) begin
                r_q[r_wr] <= it;
                r_wr <= !r_wr;
            end
            if (i_q_pop) r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/dwt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dwt_back
    import dwt_pkg::*;
#(
    parameter int REG_IDS     = REG_IDS_DEF,
    parameter int MEM_ENTRIES = MEM_ENTRIES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    output logic                   o_q_pop,
    input  wire t_item             i_q_item,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_committed,
    output logic [CNT_W-1:0]       o_dead_count,
    output logic [CTX_W-1:0]       o_first_writer,
    output logic [CTX_W-1:0]       o_killing_writer,
    output logic                   o_table_full,
    output logic [TOT_W-1:0]       o_reg_dead_total,
    output logic [TOT_W-1:0]       o_mem_dead_total
);
    localparam int RW = $clog2(REG_IDS);
    localparam int MW = $clog2(MEM_ENTRIES);

    // register file entries as memory, read registered in stage 1
    logic [CNT_W-1:0] r_rcnt [REG_IDS];
    logic [CTX_W-1:0] r_rfst [REG_IDS];
    logic [CTX_W-1:0] r_rlst [REG_IDS];
    logic [REG_IDS-1:0] r_rpend;

    logic [ADDR_W-1:0] r_mtag [MEM_ENTRIES];
    logic [CNT_W-1:0]  r_mcnt [MEM_ENTRIES];
    logic [CTX_W-1:0]  r_mfst [MEM_ENTRIES];
    logic [CTX_W-1:0]  r_mlst [MEM_ENTRIES];
    logic [MEM_ENTRIES-1:0] r_mpend;

    logic [TOT_W-1:0] r_rtot, r_mtot;

    // stage 1: lookup; stage 2: update and result
    logic r_s1;
    t_item r_it;
    logic r_hit, r_free_ok;
    logic [MW-1:0] r_hidx, r_fidx;
    logic [CNT_W-1:0] r_cnt;
    logic [CTX_W-1:0] r_fst, r_lst;
    logic r_pend;

    logic r_ov;
    logic r_ocom, r_ofull;
    logic [CNT_W-1:0] r_ocnt;
    logic [CTX_W-1:0] r_ofst, r_olst;

    logic [MEM_ENTRIES-1:0] match;
    logic hit, free_ok;
    logic [MW-1:0] hidx, fidx;
    logic adv, pop;
    logic [RW-1:0] ra;
    logic [RW-1:0] wa;
    logic [RW+REG_W-1:0] ra_ext;
    logic [RW+REG_W-1:0] wa_ext;

    always_comb begin
        for (int i = 0; i < MEM_ENTRIES; i++)
            match[i] = r_mpend[i] && (r_mtag[i] == i_q_item.address);
        hit = 1'b0; hidx = '0; free_ok = 1'b0; fidx = '0;
        for (int i = MEM_ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin hit = 1'b1; hidx = MW'(i); end
            if (!r_mpend[i]) begin free_ok = 1'b1; fidx = MW'(i); end
        end
    end

    // one item in flight keeps the stored state consistent
    assign adv   = !r_ov || !i_stall;
    assign pop   = i_q_valid && !r_s1 && adv;
    assign o_q_pop = pop;
    assign ra_ext = {{RW{1'b0}}, i_q_item.reg_number};
    assign wa_ext = {{RW{1'b0}}, r_it.reg_number};
    assign ra    = ra_ext[RW-1:0];
    assign wa    = wa_ext[RW-1:0];

    logic eff;
    logic [CNT_W-1:0] ccnt;
    logic [CTX_W-1:0] cfst;
    logic [MW-1:0] mi;
    logic com;
    logic [TOT_W:0] sum;

    always_comb begin
        mi   = r_hit ? r_hidx : r_fidx;
        eff  = r_it.is_mem ? (r_hit || (r_it.is_write && r_free_ok)) : r_it.reg_ok;
        ccnt = r_cnt;
        cfst = r_fst;
        com  = eff && !r_it.is_write && r_pend && (r_cnt != '0);
        sum  = {1'b0, r_it.is_mem ? r_mtot : r_rtot} + {{(TOT_W-CNT_W+1){1'b0}}, r_cnt};
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_it  <= i_q_item;
            if (i_q_item.is_mem) begin
                r_cnt <= r_mcnt[hidx];
                r_fst <= r_mfst[hidx];
                r_lst <= r_mlst[hidx];
            end else begin
                r_cnt <= r_rcnt[ra];
                r_fst <= r_rfst[ra];
                r_lst <= r_rlst[ra];
            end
            r_hidx <= hidx;
            r_fidx <= fidx;
        end
        if (r_s1 && eff) begin
            if (r_it.is_mem) begin
                if (r_it.is_write) begin
                    if (r_pend && r_hit) begin
                        if (ccnt != '1) r_mcnt[mi] <= ccnt + 1'b1;
                        r_mlst[mi] <= r_it.ctx;
                    end else begin
                        r_mtag[mi] <= r_it.address;
                        r_mcnt[mi] <= '0;
                        r_mfst[mi] <= r_it.ctx;
                        r_mlst[mi] <= '0;
                    end
                end
            end else if (r_it.is_write) begin
                if (r_pend) begin
                    if (ccnt != '1) r_rcnt[wa] <= ccnt + 1'b1;
                    r_rlst[wa] <= r_it.ctx;
                end else begin
                    r_rcnt[wa] <= '0;
                    r_rfst[wa] <= r_it.ctx;
                    r_rlst[wa] <= '0;
                end
            end
        end
        if (r_s1) begin
            r_ocom  <= com;
            r_ocnt  <= com ? r_cnt : '0;
            r_ofst  <= com ? cfst : '0;
            r_olst  <= com ? r_lst : '0;
            r_ofull <= r_it.is_mem && r_it.is_write && !r_hit && !r_free_ok;
        end
    end

    // stage valids, pending bits and totals; memory pending bits are indexed by the hit or free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1    <= 1'b0;
            r_ov    <= 1'b0;
            r_rpend <= '0;
            r_mpend <= '0;
            r_rtot  <= '0;
            r_mtot  <= '0;
            r_hit   <= 1'b0;
            r_free_ok <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            if (pop) begin
                r_s1 <= 1'b1;
                r_hit <= hit;
                r_free_ok <= free_ok;
                r_pend <= i_q_item.is_mem ? hit : r_rpend[ra];
            end else if (r_s1) begin
                r_s1 <= 1'b0;
                r_ov <= 1'b1;
                if (eff) begin
                    if (r_it.is_mem) r_mpend[mi] <= r_it.is_write;
                    else r_rpend[wa] <= r_it.is_write;
                end
                if (com) begin
                    if (r_it.is_mem) r_mtot <= sum[TOT_W] ? '1 : sum[TOT_W-1:0];
                    else r_rtot <= sum[TOT_W] ? '1 : sum[TOT_W-1:0];
                end
            end
        end
    end

    assign o_valid          = r_ov;
    assign o_committed      = r_ocom;
    assign o_dead_count     = r_ocnt;
    assign o_first_writer   = r_ofst;
    assign o_killing_writer = r_olst;
    assign o_table_full     = r_ofull;
    assign o_reg_dead_total = r_rtot;
    assign o_mem_dead_total = r_mtot;
endmodule
`default_nettype wire

// ===== rtl/dead_write_tracker_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake          fields
// input     in         i_valid / o_stall  operation is_memory reg_number address access_context
// output    out        o_valid / i_stall  committed dead_count writers table_full totals
// an item passes the back end as a lookup, then an update; only one item is in flight,
// so the back end takes no new item until the last one is through, due to the read-modify-write of the tables.
// the front queue holds 2 items and accepts, until it is full, while the back end or output stalls.
// reset is synchronous and clears pending bits and totals.
module dead_write_tracker_core
    import dwt_pkg::*;
#(
    parameter int REG_IDS     = REG_IDS_DEF,
    parameter int MEM_ENTRIES = MEM_ENTRIES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic              i_operation,
    input  wire logic              i_is_memory,
    input  wire logic [REG_W-1:0]  i_reg_number,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic [CTX_W-1:0]  i_access_context,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_committed,
    output logic [CNT_W-1:0]       o_dead_count,
    output logic [CTX_W-1:0]       o_first_writer,
    output logic [CTX_W-1:0]       o_killing_writer,
    output logic                   o_table_full,
    output logic [TOT_W-1:0]       o_reg_dead_total,
    output logic [TOT_W-1:0]       o_mem_dead_total
);
    logic  q_valid, q_pop;
    t_item q_item;

    dwt_front #(.REG_IDS(REG_IDS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_operation, .i_is_memory,
        .i_reg_number, .i_address, .i_access_context,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_item(q_item)
    );

    dwt_back #(.REG_IDS(REG_IDS), .MEM_ENTRIES(MEM_ENTRIES)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_item(q_item),
        .o_valid, .i_stall, .o_committed, .o_dead_count, .o_first_writer,
        .o_killing_writer, .o_table_full, .o_reg_dead_total, .o_mem_dead_total
    );
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import dwt_pkg::*;

    typedef struct {
        logic              committed;
        logic [CNT_W-1:0]  dead_count;
        logic [CTX_W-1:0]  first_writer;
        logic [CTX_W-1:0]  killing_writer;
        logic              table_full;
        logic [TOT_W-1:0]  reg_total;
        logic [TOT_W-1:0]  mem_total;
    } t_verdict;

    class dead_write_board;
        bit               reg_open [REG_IDS_DEF];
        bit [CNT_W-1:0]   reg_cnt [REG_IDS_DEF];
        bit [CTX_W-1:0]   reg_first [REG_IDS_DEF];
        bit [CTX_W-1:0]   reg_kill [REG_IDS_DEF];
        bit               mem_open [MEM_ENTRIES_DEF];
        bit [ADDR_W-1:0]  mem_addr [MEM_ENTRIES_DEF];
        bit [CNT_W-1:0]   mem_cnt [MEM_ENTRIES_DEF];
        bit [CTX_W-1:0]   mem_first [MEM_ENTRIES_DEF];
        bit [CTX_W-1:0]   mem_kill [MEM_ENTRIES_DEF];
        bit [TOT_W-1:0]   reg_sum;
        bit [TOT_W-1:0]   mem_sum;
        t_verdict         pending_q [$];
        int               errors;
        int               commits;
        int               fulls;
        int               checked;

        function void clear();
            foreach (reg_open[i]) reg_open[i] = 0;
            foreach (mem_open[i]) mem_open[i] = 0;
            reg_sum = 0;
            mem_sum = 0;
        endfunction

        function bit [TOT_W-1:0] sat_add(bit [TOT_W-1:0] a, bit [CNT_W-1:0] b);
            bit [TOT_W:0] s;
            s = a + b;
            return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
        endfunction

        function void note_access(logic wr, logic mem, logic [REG_W-1:0] rn,
                                  logic [ADDR_W-1:0] addr, logic [CTX_W-1:0] ctx);
            t_verdict v;
            int hit;
            int fre;
            v = '{default: 0};
            if (!mem) begin
                if (wr) begin
                    if (reg_open[rn]) begin
                        if (reg_cnt[rn] != '1) reg_cnt[rn]++;
                        reg_kill[rn] = ctx;
                    end else begin
                        reg_open[rn] = 1;
                        reg_cnt[rn] = 0;
                        reg_first[rn] = ctx;
                        reg_kill[rn] = 0;
                    end
                end else if (reg_open[rn]) begin
                    reg_open[rn] = 0;
                    if (reg_cnt[rn] != 0) begin
                        v.committed = 1;
                        v.dead_count = reg_cnt[rn];
                        v.first_writer = reg_first[rn];
                        v.killing_writer = reg_kill[rn];
                        reg_sum = sat_add(reg_sum, reg_cnt[rn]);
                    end
                end
            end else begin
                hit = -1;
                fre = -1;
                for (int i = 0; i < MEM_ENTRIES_DEF; i++) begin
                    if (mem_open[i]) begin
                        if (hit < 0 && mem_addr[i] == addr) hit = i;
                    end else if (fre < 0) begin
                        fre = i;
                    end
                end
                if (hit >= 0) begin
                    if (wr) begin
                        if (mem_cnt[hit] != '1) mem_cnt[hit]++;
                        mem_kill[hit] = ctx;
                    end else begin
                        mem_open[hit] = 0;
                        if (mem_cnt[hit] != 0) begin
                            v.committed = 1;
                            v.dead_count = mem_cnt[hit];
                            v.first_writer = mem_first[hit];
                            v.killing_writer = mem_kill[hit];
                            mem_sum = sat_add(mem_sum, mem_cnt[hit]);
                        end
                    end
                end else if (wr) begin
                    if (fre >= 0) begin
                        mem_open[fre] = 1;
                        mem_addr[fre] = addr;
                        mem_cnt[fre] = 0;
                        mem_first[fre] = ctx;
                        mem_kill[fre] = 0;
                    end else begin
                        v.table_full = 1;
                    end
                end
            end
            v.reg_total = reg_sum;
            v.mem_total = mem_sum;
            pending_q.push_back(v);
        endfunction

        function void report(string name, longint unsigned e, longint unsigned a);
            if (e != a) begin
                errors++;
                $display("%0t: %s mismatch expected %0h actual %0h", $time, name, e, a);
            end
        endfunction

        function void check_result(t_verdict got);
            t_verdict e;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual committed %0b",
                         $time, got.committed);
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (got.committed === 1'b1) commits++;
            if (got.table_full === 1'b1) fulls++;
            if ($isunknown(got.committed) || $isunknown(got.dead_count) ||
                $isunknown(got.first_writer) || $isunknown(got.killing_writer) ||
                $isunknown(got.table_full) || $isunknown(got.reg_total) ||
                $isunknown(got.mem_total)) begin
                errors++;
                $display("%0t: unknown bits in result, expected known actual x", $time);
            end
            report("committed", e.committed, got.committed);
            report("dead_count", e.dead_count, got.dead_count);
            report("first_writer", e.first_writer, got.first_writer);
            report("killing_writer", e.killing_writer, got.killing_writer);
            report("table_full", e.table_full, got.table_full);
            report("reg_dead_total", e.reg_total, got.reg_total);
            report("mem_dead_total", e.mem_total, got.mem_total);
        endfunction
    endclass

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_valid = 0;
    logic              o_stall;
    logic              i_operation = 0;
    logic              i_is_memory = 0;
    logic [REG_W-1:0]  i_reg_number = 0;
    logic [ADDR_W-1:0] i_address = 0;
    logic [CTX_W-1:0]  i_access_context = 0;
    logic              o_valid;
    logic              i_stall = 1;
    logic              o_committed;
    logic [CNT_W-1:0]  o_dead_count;
    logic [CTX_W-1:0]  o_first_writer;
    logic [CTX_W-1:0]  o_killing_writer;
    logic              o_table_full;
    logic [TOT_W-1:0]  o_reg_dead_total;
    logic [TOT_W-1:0]  o_mem_dead_total;

    dead_write_tracker_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(i_operation), .i_is_memory(i_is_memory),
        .i_reg_number(i_reg_number), .i_address(i_address),
        .i_access_context(i_access_context),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_committed(o_committed), .o_dead_count(o_dead_count),
        .o_first_writer(o_first_writer), .o_killing_writer(o_killing_writer),
        .o_table_full(o_table_full), .o_reg_dead_total(o_reg_dead_total),
        .o_mem_dead_total(o_mem_dead_total)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    dead_write_board board;
    bit  calm_period;
    bit  hold_off;
    bit  stim_done;
    int  sent;
    longint cycles;
    logic [ADDR_W-1:0] addr_pool [16];

    initial board = new();

    // output side: random stall, no stall in the calm period, long hold-off when asked
    always @(posedge i_clk) begin
        t_verdict got;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            got.committed = o_committed;
            got.dead_count = o_dead_count;
            got.first_writer = o_first_writer;
            got.killing_writer = o_killing_writer;
            got.table_full = o_table_full;
            got.reg_total = o_reg_dead_total;
            got.mem_total = o_mem_dead_total;
            board.check_result(got);
        end
        if (!i_rst_n) i_stall <= 1;
        else if (hold_off) i_stall <= 1;
        else if (calm_period) i_stall <= 0;
        else i_stall <= ($urandom_range(99) < 16);
    end

    initial begin
        hold_off = 0;
        wait (sent >= 300);
        hold_off = 1;
        repeat (200) @(posedge i_clk);
        hold_off = 0;
    end

    task automatic send_access(logic wr, logic mem, logic [REG_W-1:0] rn,
                               logic [ADDR_W-1:0] addr, logic [CTX_W-1:0] ctx);
        if (!calm_period) begin
            while ($urandom_range(99) < 16) begin
                i_valid <= 0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1;
        i_operation <= wr;
        i_is_memory <= mem;
        i_reg_number <= rn;
        i_address <= addr;
        i_access_context <= ctx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_access(wr, mem, rn, addr, ctx);
        sent++;
    endtask

    task automatic send_random();
        int k;
        logic wr;
        logic mem;
        logic [REG_W-1:0] rn;
        logic [ADDR_W-1:0] addr;
        k = $urandom_range(99);
        wr = ($urandom_range(99) < 60);
        mem = ($urandom_range(1) == 1);
        rn = (k < 80) ? REG_W'($urandom_range(15)) : REG_W'($urandom);
        if (k < 85) addr = addr_pool[$urandom_range(15)];
        else addr = ADDR_W'({$urandom, $urandom});
        send_access(wr, mem, rn, addr, CTX_W'($urandom));
    endtask

    initial begin
        int ops;
        cycles = 0;
        sent = 0;
        stim_done = 0;
        calm_period = 0;
        board.clear();
        foreach (addr_pool[i]) addr_pool[i] = ADDR_W'({$urandom, $urandom});
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: extremes, untracked read, zero-count close, dead run
        send_access(OP_READ, 0, 8'd5, 0, 0);
        send_access(OP_WRITE, 0, 8'd0, 0, '0);
        send_access(OP_READ, 0, 8'd0, 0, 0);
        send_access(OP_WRITE, 0, 8'hff, 0, '1);
        send_access(OP_WRITE, 0, 8'hff, 0, 31'h2aaa_aaaa);
        send_access(OP_WRITE, 0, 8'hff, 0, 31'h5555_5555);
        send_access(OP_READ, 0, 8'hff, '1, '1);
        send_access(OP_WRITE, 1, 8'hff, '0, 31'd7);
        send_access(OP_WRITE, 1, 0, '1, 31'd8);
        send_access(OP_WRITE, 1, 0, '1, '1);
        send_access(OP_READ, 1, 0, '1, 0);
        send_access(OP_READ, 1, 0, '0, 0);
        send_access(OP_READ, 1, 0, 48'h1234, 0);
        // fill the memory table, then overflow, then reuse lowest freed slot
        for (int i = 0; i < MEM_ENTRIES_DEF + 2; i++)
            send_access(OP_WRITE, 1, 0, ADDR_W'(i * 64 + 3), CTX_W'(i));
        send_access(OP_WRITE, 1, 0, ADDR_W'(3), 31'd99);
        send_access(OP_READ, 1, 0, ADDR_W'(3), 0);
        send_access(OP_WRITE, 1, 0, 48'hdead_beef, 31'd1);
        for (int i = 0; i < MEM_ENTRIES_DEF; i++)
            send_access(OP_READ, 1, 0, ADDR_W'(i * 64 + 3), 0);
        send_access(OP_READ, 1, 0, 48'hdead_beef, 0);
        ops = 0;
        while (ops < 1000) begin
            calm_period = (ops >= 500 && ops < 650);
            send_random();
            ops++;
        end
        calm_period = 0;
        i_valid <= 0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (board.pending_q.size() != 0 && cycles < 3_000_000) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("tb: %0d results checked, %0d committed dead runs, %0d table-full drops",
                 board.checked, board.commits, board.fulls);
        $display("tb: covered full table, slot reuse, output hold-off and register/memory runs");
        if (board.errors == 0 && board.pending_q.size() == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end

    initial begin
        wait (cycles >= 3_000_000);
        $display("tb: FAIL");
        $finish;
    end
endmodule
